// File: src/sib_pkg.sv
package sib_pkg;

    localparam int DATA_W       = 32;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int FILL_W       = 7;
    localparam int CAPACITY_DEF = 16;

    localparam logic [CMD_W-1:0] CMD_INSERT       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ_SORTED  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_ARRIVAL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR        = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic                     ins;
        logic                     rot;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

    // signed order as unsigned order
    function automatic logic [DATA_W-1:0] order_key(input logic [DATA_W-1:0] v);
        order_key = {~v[DATA_W-1], v[DATA_W-2:0]};
    endfunction

endpackage

// File: src/sib_cell.sv
module sib_cell
    import sib_pkg::*;
#(
    parameter int IDX = 0,
    parameter int FW  = 5
)
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic [FW-1:0]            fill,
    input  logic                     gt_left,
    input  logic signed [DATA_W-1:0] left_s,
    input  logic signed [DATA_W-1:0] right_s,
    input  logic signed [DATA_W-1:0] right_a,
    input  logic signed [DATA_W-1:0] head_s,
    input  logic signed [DATA_W-1:0] head_a,
    output logic                     gt,
    output logic signed [DATA_W-1:0] s_out,
    output logic signed [DATA_W-1:0] a_out
);

    logic signed [DATA_W-1:0] s_reg;
    logic signed [DATA_W-1:0] s_next;
    logic signed [DATA_W-1:0] a_reg;
    logic signed [DATA_W-1:0] a_next;
    logic                     wrap;
    logic                     at_fill;

    // gt: this entry is empty or holds a larger value, so it moves right
    assign gt      = (FW'(IDX) >= fill) || (order_key(s_reg) > order_key(ctrl.value));
    assign wrap    = ((FW'(IDX) + FW'(1)) == fill);
    assign at_fill = (FW'(IDX) == fill);

    always_comb
    begin
        s_next = s_reg;
        a_next = a_reg;
        if (ctrl.ins)
        begin
            if (gt)
            begin
                s_next = gt_left ? left_s : ctrl.value;
            end
            if (at_fill)
            begin
                a_next = ctrl.value;
            end
        end
        else if (ctrl.rot)
        begin
            s_next = wrap ? head_s : right_s;
            a_next = wrap ? head_a : right_a;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        a_reg <= a_next;
    end

    assign s_out = s_reg;
    assign a_out = a_reg;

endmodule

// File: src/sorted_insertion_buffer.sv
// Channel  Handshake              Payload
// in       in_valid / in_ready    cmd, value
// out      out_valid / out_ready  status, data, last, fill
//
// Insert and clear: one result each, back to back when out is free.
// Read: one result per held value (one if empty), one per cycle while out is free;
// the value chain rotates by one cell each transfer.
// Async active-low reset empties the buffer; stored values are not reset.
// A stalled out register holds the chain and blocks further input.
module sorted_insertion_buffer
    import sib_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [CMD_W-1:0]           cmd,
    input  logic signed [DATA_W-1:0]   value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [STATUS_W-1:0]        status,
    output logic signed [DATA_W-1:0]   data,
    output logic                       last,
    output logic [FILL_W-1:0]          fill
);

    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = $clog2(CAPACITY);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_STREAM = 1'b1;

    logic                     state_reg, state_next;
    logic                     sel_sorted_reg, sel_sorted_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [FW-1:0]            fill_reg, fill_next;
    logic                     out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic signed [DATA_W-1:0] data_reg, data_next;
    logic                     last_reg, last_next;
    logic [FILL_W-1:0]        fill_out_reg, fill_out_next;

    logic                     out_free;
    logic                     acc;
    logic                     stream_step;
    logic                     stream_last;
    logic                     has_room;
    cell_ctrl_t               ctrl;

    logic                     gt_w [CAPACITY];
    logic signed [DATA_W-1:0] s_w  [CAPACITY];
    logic signed [DATA_W-1:0] a_w  [CAPACITY];

    assign out_free    = !out_valid_reg || out_ready;
    assign in_ready    = (state_reg == S_IDLE) && out_free;
    assign acc         = in_valid && in_ready;
    assign stream_step = (state_reg == S_STREAM) && out_free;
    assign stream_last = ((FW'(cnt_reg) + FW'(1)) == fill_reg);
    assign has_room    = (fill_reg < FW'(CAPACITY));

    assign ctrl.ins   = acc && (cmd == CMD_INSERT) && has_room;
    assign ctrl.rot   = stream_step;
    assign ctrl.value = value;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                     gl;
            logic signed [DATA_W-1:0] ls;
            logic signed [DATA_W-1:0] rs;
            logic signed [DATA_W-1:0] ra;

            if (gi == 0)
            begin : g_first
                assign gl = 1'b0;
                assign ls = value;
            end
            else
            begin : g_mid
                assign gl = gt_w[gi-1];
                assign ls = s_w[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_end
                assign rs = s_w[0];
                assign ra = a_w[0];
            end
            else
            begin : g_inner
                assign rs = s_w[gi+1];
                assign ra = a_w[gi+1];
            end

            sib_cell #(
                .IDX (gi),
                .FW  (FW)
            ) u_cell (
                .clk     (clk),
                .ctrl    (ctrl),
                .fill    (fill_reg),
                .gt_left (gl),
                .left_s  (ls),
                .right_s (rs),
                .right_a (ra),
                .head_s  (s_w[0]),
                .head_a  (a_w[0]),
                .gt      (gt_w[gi]),
                .s_out   (s_w[gi]),
                .a_out   (a_w[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        sel_sorted_next = sel_sorted_reg;
        cnt_next        = cnt_reg;
        fill_next       = fill_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        data_next       = data_reg;
        last_next       = last_reg;
        fill_out_next   = fill_out_reg;

        if (acc)
        begin
            data_next = '0;
            last_next = 1'b1;
            unique case (cmd)
                CMD_INSERT:
                begin
                    out_valid_next = 1'b1;
                    if (has_room)
                    begin
                        fill_next     = fill_reg + FW'(1);
                        status_next   = STAT_OK;
                        fill_out_next = FILL_W'(fill_reg + FW'(1));
                    end
                    else
                    begin
                        status_next   = STAT_FULL;
                        fill_out_next = FILL_W'(fill_reg);
                    end
                end
                CMD_READ_SORTED, CMD_READ_ARRIVAL:
                begin
                    sel_sorted_next = (cmd == CMD_READ_SORTED);
                    if (fill_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = STAT_EMPTY;
                        fill_out_next  = '0;
                    end
                    else
                    begin
                        state_next = S_STREAM;
                        cnt_next   = '0;
                    end
                end
                CMD_CLEAR:
                begin
                    out_valid_next = 1'b1;
                    fill_next      = '0;
                    status_next    = STAT_OK;
                    fill_out_next  = '0;
                end
                default:
                begin
                    out_valid_next = 1'b0;
                end
            endcase
        end
        else if (stream_step)
        begin
            out_valid_next = 1'b1;
            status_next    = STAT_OK;
            data_next      = sel_sorted_reg ? s_w[0] : a_w[0];
            last_next      = stream_last;
            fill_out_next  = FILL_W'(fill_reg);
            if (stream_last)
            begin
                state_next = S_IDLE;
                cnt_next   = '0;
            end
            else
            begin
                cnt_next = cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sel_sorted_reg <= 1'b0;
            cnt_reg        <= '0;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sel_sorted_reg <= sel_sorted_next;
            cnt_reg        <= cnt_next;
            fill_reg       <= fill_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        data_reg     <= data_next;
        last_reg     <= last_next;
        fill_out_reg <= fill_out_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign last      = last_reg;
    assign fill      = fill_out_reg;

endmodule
